FILE: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file for its checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lsbse_pkg.sv
`default_nettype none

package lsbse_pkg;

    // Configuration port.
    localparam int CFG_DW = 64;
    localparam int CFG_IW = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IW-1:0] REG_BITS_PER_BYTE = 2'd0;
    localparam logic [CFG_IW-1:0] REG_KEY_WORD      = 2'd1;
    localparam logic [CFG_IW-1:0] REG_KEY_LENGTH    = 2'd2;

    localparam int BPB_W     = 4;
    localparam int KEY_LEN_W = 7;
    localparam int BPB_MAX   = 8;

    // Frame flag 0,1,1,1,1,1,1,0 sent first bit at bit 0.
    localparam logic [7:0] FLAG_PATTERN = 8'h7E;

    // A zero is stuffed when a one arrives with this many ones already seen.
    localparam logic [2:0] RUN_LIMIT = 3'd4;

    typedef enum logic [1:0] {
        FUNC_PAYLOAD = 2'd0,
        FUNC_FLAG    = 2'd1,
        FUNC_FINISH  = 2'd2,
        FUNC_COVER   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_SHORT    = 2'd2,
        ST_FINISHED = 2'd3
    } t_status;

    // Requests from the sequencer to the bit queue.
    typedef struct packed {
        logic push;
        logic push_bit;
        logic pop;
    } t_q_ctrl;

endpackage

`default_nettype wire

FILE: rtl/lsbse_bitq.sv
`default_nettype none

// Circular one-bit queue with a registered read of the oldest entry.
module lsbse_bitq #(
    parameter int QUEUE_DEPTH = 32,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsbse_pkg::t_q_ctrl i_ctrl,
    output logic [CW-1:0]          o_count,
    output logic                   o_rd_bit
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    logic          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_head;
    logic [AW-1:0] r_tail;
    logic [CW-1:0] r_count;
    logic          r_rd_bit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_ctrl.push_bit;
        end
        r_rd_bit <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_tail <= (r_tail == LAST) ? '0 : r_tail + AW'(1);
            end
            if (i_ctrl.pop) begin
                r_head <= (r_head == LAST) ? '0 : r_head + AW'(1);
            end
            r_count <= r_count + CW'(i_ctrl.push) - CW'(i_ctrl.pop);
        end
    end

    assign o_count  = r_count;
    assign o_rd_bit = r_rd_bit;

endmodule

`default_nettype wire

FILE: rtl/lsb_stego_embedder_top.sv
`default_nettype none

// Hides a keyed, bit-stuffed payload in the low bits of a stream of cover bytes. Payload
// bytes are split first bit at bit 0, a zero follows every fifth consecutive one, and every
// bit is XORed with the next bit of the cycling key before it enters a QUEUE_DEPTH bit queue.
// A flag item queues the keyed pattern 01111110 unstuffed, and finish queues one keyed zero
// and starts draining. Each cover byte gets its low bits_per_byte bits replaced by the
// oldest queued bits; once the queue has drained, cover bytes pass through unchanged. Every
// transaction on the input returns exactly one transaction on the output with a status code.
// One item is handled at a time, and all bits move through a single bit-serial path into and
// out of the queue memory, one bit per cycle. A payload, flag or finish item is first walked
// dry to count the bits it would queue and, if they fit, walked again to push them; an item
// turned away because the queue is full ends after the dry walk. An embedding cover byte
// pops its bits one at a time, and a pass-through, short or already-finished item goes
// straight to its result. The next transaction is accepted in the cycle after the result is
// loaded into the output register, even while that result still waits to be taken.
// Configuration must be written while the block is idle; bits_per_byte outside 1 to 8 and
// key_length outside 1 to KEY_BITS are clamped into range.

`include "assert_macros.svh"

module lsb_stego_embedder_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int KEY_BITS    = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [lsbse_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire logic [lsbse_pkg::CFG_DW-1:0]   i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_func,
    input  wire logic [7:0]                     i_data,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [7:0]                          o_stego_byte,
    output logic                                o_stego_valid,
    output logic [5:0]                          o_queue_level,
    output logic [1:0]                          o_status
);

    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int KPW = $clog2(KEY_BITS);
    localparam int KLW = lsbse_pkg::KEY_LEN_W;
    localparam int BW  = lsbse_pkg::BPB_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRY,
        S_PUSH,
        S_POP,
        S_DONE
    } t_state;

    // Embedding, draining after finish, and plain pass through.
    typedef enum logic [1:0] {
        PH_EMBED,
        PH_DRAIN,
        PH_PASS
    } t_phase;

    // Configuration registers.
    logic [BW-1:0]       r_bpb;
    logic [KEY_BITS-1:0] r_key_word;
    logic [KLW-1:0]      r_key_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpb      <= BW'(1);
            r_key_word <= '0;
            r_key_len  <= KLW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lsbse_pkg::REG_BITS_PER_BYTE: r_bpb      <= i_cfg_data[BW-1:0];
                lsbse_pkg::REG_KEY_WORD:      r_key_word <= i_cfg_data[KEY_BITS-1:0];
                lsbse_pkg::REG_KEY_LENGTH:    r_key_len  <= i_cfg_data[KLW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state.
    t_state               r_state;
    t_phase               r_phase;
    lsbse_pkg::t_func     r_func;
    logic [7:0]           r_data;
    logic [7:0]           r_src;
    logic [3:0]           r_nbits;
    logic                 r_stuff_en;
    logic [3:0]           r_idx;
    logic                 r_pend;
    logic [2:0]           r_run;
    logic [2:0]           r_ones_run;
    logic [3:0]           r_need;
    logic [KPW-1:0]       r_key_pos;
    logic [3:0]           r_take;
    logic [3:0]           r_cnt;
    logic [7:0]           r_bits;
    lsbse_pkg::t_status   r_res_status;
    logic                 r_res_valid;
    logic                 r_res_emb;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_sv;
    logic [5:0]           r_out_level;
    lsbse_pkg::t_status   r_out_status;

    lsbse_pkg::t_q_ctrl   q_ctrl;
    logic [CW-1:0]        q_count;
    logic                 q_rd_bit;

    logic [BW-1:0]  w_bpb;
    logic [KLW-1:0] w_key_len;
    logic           w_walk_end;
    logic           w_cur_bit;
    logic           w_key_bit;
    logic           w_key_wrap;
    logic           w_fit;
    logic           w_short;
    logic [3:0]     w_take;
    logic [7:0]     w_mask;

    // Out-of-range register values are clamped the same way everywhere.
    assign w_bpb = (r_bpb == '0) ? BW'(1) :
                   (r_bpb > BW'(lsbse_pkg::BPB_MAX)) ? BW'(lsbse_pkg::BPB_MAX) : r_bpb;
    assign w_key_len = (r_key_len == '0) ? KLW'(1) :
                       (r_key_len > KLW'(KEY_BITS)) ? KLW'(KEY_BITS) : r_key_len;

    // The bit walker serves payload, flag and finish items. A pending stuff bit is a zero
    // that is emitted before the walker moves on to the next source bit.
    assign w_walk_end = !r_pend && (r_idx == r_nbits);
    assign w_cur_bit  = !r_pend && r_src[r_idx[2:0]];
    assign w_key_bit  = r_key_word[r_key_pos];
    assign w_key_wrap = (KLW'(r_key_pos) + KLW'(1)) >= w_key_len;

    // The dry walk counts the bits an item will queue, so it is rejected as a whole or not.
    assign w_fit = ({1'b0, q_count} + (CW + 1)'(r_need)) <= (CW + 1)'(QUEUE_DEPTH);

    assign w_short = q_count < CW'(w_bpb);
    assign w_take  = w_short ? 4'(q_count) : w_bpb;
    assign w_mask  = 8'(8'hFF << w_bpb);

    assign q_ctrl.push     = (r_state == S_PUSH) && !w_walk_end;
    assign q_ctrl.push_bit = w_cur_bit ^ w_key_bit;
    assign q_ctrl.pop      = (r_state == S_POP) && (r_cnt < r_take);

    lsbse_bitq #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_bitq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (q_ctrl),
        .o_count  (q_count),
        .o_rd_bit (q_rd_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_EMBED;
            r_ones_run  <= '0;
            r_key_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func <= lsbse_pkg::t_func'(i_func);
                        r_data <= i_data;
                        r_bits <= '0;
                        if (lsbse_pkg::t_func'(i_func) == lsbse_pkg::FUNC_COVER) begin
                            if (r_phase == PH_PASS) begin
                                r_res_status <= lsbse_pkg::ST_OK;
                                r_res_valid  <= 1'b1;
                                r_res_emb    <= 1'b0;
                                r_state      <= S_DONE;
                            end else if (r_phase == PH_EMBED && w_short) begin
                                r_res_status <= lsbse_pkg::ST_SHORT;
                                r_res_valid  <= 1'b0;
                                r_res_emb    <= 1'b0;
                                r_state      <= S_DONE;
                            end else begin
                                r_take       <= w_take;
                                r_cnt        <= '0;
                                r_res_status <= lsbse_pkg::ST_OK;
                                r_res_valid  <= 1'b1;
                                r_res_emb    <= 1'b1;
                                r_state      <= S_POP;
                            end
                        end else if (r_phase != PH_EMBED) begin
                            r_res_status <= lsbse_pkg::ST_FINISHED;
                            r_res_valid  <= 1'b0;
                            r_res_emb    <= 1'b0;
                            r_state      <= S_DONE;
                        end else begin
                            r_res_status <= lsbse_pkg::ST_OK;
                            r_res_valid  <= 1'b0;
                            r_res_emb    <= 1'b0;
                            r_idx        <= '0;
                            r_pend       <= 1'b0;
                            r_run        <= r_ones_run;
                            r_need       <= '0;
                            case (lsbse_pkg::t_func'(i_func))
                                lsbse_pkg::FUNC_PAYLOAD: begin
                                    r_src      <= i_data;
                                    r_nbits    <= 4'd8;
                                    r_stuff_en <= 1'b1;
                                end
                                lsbse_pkg::FUNC_FLAG: begin
                                    r_src      <= lsbse_pkg::FLAG_PATTERN;
                                    r_nbits    <= 4'd8;
                                    r_stuff_en <= 1'b0;
                                end
                                default: begin
                                    r_src      <= '0;
                                    r_nbits    <= 4'd1;
                                    r_stuff_en <= 1'b0;
                                end
                            endcase
                            r_state <= S_DRY;
                        end
                    end
                end

                S_DRY: begin
                    if (w_walk_end) begin
                        if (w_fit) begin
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                            r_run   <= r_ones_run;
                            r_state <= S_PUSH;
                        end else begin
                            r_res_status <= lsbse_pkg::ST_FULL;
                            r_state      <= S_DONE;
                        end
                    end else begin
                        r_need <= r_need + 4'd1;
                    end
                end

                S_PUSH: begin
                    if (w_walk_end) begin
                        case (r_func)
                            lsbse_pkg::FUNC_PAYLOAD: r_ones_run <= r_run;
                            lsbse_pkg::FUNC_FLAG:    r_ones_run <= '0;
                            default:                 r_phase    <= PH_DRAIN;
                        endcase
                        r_state <= S_DONE;
                    end else begin
                        r_key_pos <= w_key_wrap ? '0 : r_key_pos + KPW'(1);
                    end
                end

                S_POP: begin
                    // The queue read is registered, so each bit is captured in the cycle after its pop.
                    if (r_cnt != '0) begin
                        r_bits[3'(r_cnt - 4'd1)] <= q_rd_bit;
                    end
                    if (r_cnt < r_take) begin
                        r_cnt <= r_cnt + 4'd1;
                    end else begin
                        if (r_phase == PH_DRAIN && q_count == '0) begin
                            r_phase <= PH_PASS;
                        end
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_byte   <= r_res_emb ? ((r_data & w_mask) | r_bits) :
                                        (r_res_valid ? r_data : 8'd0);
                        r_out_sv     <= r_res_valid;
                        r_out_level  <= 6'(q_count);
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // The output register fills when a result is ready and empties once taken.
            if (r_state == S_DONE && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            // Shared step of the bit walker for the dry count and the real push.
            if ((r_state == S_DRY || r_state == S_PUSH) && !w_walk_end) begin
                if (r_pend) begin
                    r_pend <= 1'b0;
                    r_run  <= '0;
                end else begin
                    r_idx <= r_idx + 4'd1;
                    if (r_stuff_en) begin
                        if (w_cur_bit) begin
                            if (r_run == lsbse_pkg::RUN_LIMIT) begin
                                r_pend <= 1'b1;
                            end else begin
                                r_run <= r_run + 3'd1;
                            end
                        end else begin
                            r_run <= '0;
                        end
                    end
                end
            end
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_stego_byte  = r_out_byte;
    assign o_stego_valid = r_out_sv;
    assign o_queue_level = r_out_level;
    assign o_status      = r_out_status;

    // The queue never holds more bits than it has room for.
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, q_count <= CW'(QUEUE_DEPTH), "queue count overflow")
    // The overflow check must keep every push inside the queue.
    `ASSERT_IMPLIES(a_push_room, i_clk, i_rst_n, q_ctrl.push, q_count < CW'(QUEUE_DEPTH), "push into full queue")
    // Cover bytes only take bits that are really queued.
    `ASSERT_IMPLIES(a_pop_avail, i_clk, i_rst_n, q_ctrl.pop, q_count != '0, "pop from empty queue")
    // Once finish has been taken, embedding never resumes.
    `ASSERT_NEXT(a_phase_sticky, i_clk, i_rst_n, r_phase != PH_EMBED, r_phase != PH_EMBED, "phase went back to embedding")

endmodule

`default_nettype wire
